FILE: src/tpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker mode controller package
// Shared types, action and register codes, and reset values for the mode
// controller of a two-axis antenna mount.
// ----------------------------------------------------------------------------
package tpc_pkg;

    // Action codes carried by an input item. Codes above ACT_CAL act as a tick.
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_IDLE   = 3'd1;
    localparam logic [2:0] ACT_TRACK  = 3'd2;
    localparam logic [2:0] ACT_REMOTE = 3'd3;
    localparam logic [2:0] ACT_CAL    = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_REMOTE = 2'd2,
        MODE_CAL    = 2'd3
    } t_mode;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_GAIN_AZ  = 8'd0;
    localparam t_cfg_idx REG_GAIN_EL  = 8'd1;
    localparam t_cfg_idx REG_EL_UPPER = 8'd2;
    localparam t_cfg_idx REG_EL_LOWER = 8'd3;

    localparam logic [15:0]        GAIN_RESET     = 16'd256;
    localparam logic signed [15:0] EL_UPPER_RESET = 16'sd6433;
    localparam logic signed [15:0] EL_LOWER_RESET = 16'sd0;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] azimuth_command;
        logic signed [15:0] elevation_command;
        logic signed [15:0] azimuth_position;
        logic signed [15:0] elevation_position;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] azimuth_speed;
        logic signed [15:0] elevation_speed;
        logic               drives_enabled;
        t_mode              current_mode;
        logic               calibrate_azimuth_pulse;
        logic               calibrate_elevation_pulse;
    } t_out_item;

    // Current register settings as seen by the datapath.
    typedef struct packed {
        logic [15:0]        gain_azimuth;
        logic [15:0]        gain_elevation;
        logic signed [15:0] elevation_upper_limit;
        logic signed [15:0] elevation_lower_limit;
    } t_cfg_regs;

endpackage

`default_nettype wire

FILE: src/tpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface tpc_in_if
    import tpc_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tpc_out_if
    import tpc_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tpc_cfg_if
    import tpc_pkg::*;
;
    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/two_axis_tracker_mode_p_control_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker mode controller, top level
// Mode control, calibration strobes and proportional speed control for a
// two-axis antenna mount.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   carries one item per transfer: an action code (tick or mode entry),
//          the two commands and the measured pose.
//   o_out  returns exactly one result per item, in order: both drive speeds,
//          the drive-enable flag, the mode after the item and the two
//          calibrate strobes.
//   i_cfg  writes the gains and elevation limits; it is always ready and
//          should be used only while no item is in flight.
// o_out.valid rises once an accepted item has passed the input register and
// then the result register. The block takes a new item every cycle while
// the receiver takes results; the input register and the result register
// form a two-stage pipeline; the speed path is one 17x17 multiply per axis.
// If the receiver stalls, the result is held in the result register and one
// more item waits in the input register before i_in.ready drops.
// Synchronous reset returns the mode to idle, clears both calibrated flags
// and the drive enable, empties both stages and reloads the register
// defaults.
// ----------------------------------------------------------------------------
module two_axis_tracker_mode_p_control_top
    import tpc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpc_in_if.sink     i_in,
    tpc_out_if.source  o_out,
    tpc_cfg_if.sink    i_cfg
);

    t_cfg_regs regs;

    tpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (regs)
    );

    tpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_regs  (regs),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: src/tpc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker configuration registers
// Holds the gains and elevation limits; takes one register write per cycle.
// ----------------------------------------------------------------------------
module tpc_cfg
    import tpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tpc_cfg_if.sink     i_cfg,
    output t_cfg_regs   o_regs
);

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_comb begin
        n_regs = r_regs;
        if (i_cfg.valid) begin
            // Writes to indexes past the last register are dropped.
            unique case (i_cfg.index)
                REG_GAIN_AZ:  n_regs.gain_azimuth          = i_cfg.data;
                REG_GAIN_EL:  n_regs.gain_elevation        = i_cfg.data;
                REG_EL_UPPER: n_regs.elevation_upper_limit = $signed(i_cfg.data);
                REG_EL_LOWER: n_regs.elevation_lower_limit = $signed(i_cfg.data);
                default:      n_regs = r_regs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.gain_azimuth          <= GAIN_RESET;
            r_regs.gain_elevation        <= GAIN_RESET;
            r_regs.elevation_upper_limit <= EL_UPPER_RESET;
            r_regs.elevation_lower_limit <= EL_LOWER_RESET;
        end else begin
            r_regs <= n_regs;
        end
    end

endmodule

`default_nettype wire

FILE: src/tpc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker mode and speed datapath
// Input register, mode/calibration state, proportional control and the
// result register. One item can move through each stage every cycle while the receiver takes results.
// ----------------------------------------------------------------------------
module tpc_core
    import tpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg_regs i_regs,
    tpc_in_if.sink         i_in,
    tpc_out_if.source      o_out
);

    // Gain (unsigned Q8.8) times error (17-bit signed), floor shift by 8,
    // saturated to a signed 16-bit speed.
    function automatic logic signed [15:0] prop_gain(
        input logic [15:0]        gain,
        input logic signed [16:0] err
    );
        logic signed [33:0] prod;
        logic signed [25:0] quot;
        begin
            prod = $signed({1'b0, gain}) * err;
            quot = prod[33:8];
            if (quot[25:15] == {11{quot[25]}}) begin
                prop_gain = quot[15:0];
            end else if (quot[25]) begin
                prop_gain = 16'sh8000;
            end else begin
                prop_gain = 16'sh7FFF;
            end
        end
    endfunction

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    t_mode     r_mode;
    t_mode     n_mode;
    logic      r_cal_az;
    logic      n_cal_az;
    logic      r_cal_el;
    logic      n_cal_el;
    logic      r_enabled;
    logic      n_enabled;
    t_out_item n_out;

    logic               advance;
    logic               both_cal;
    logic signed [15:0] el_target;
    logic signed [16:0] az_err;
    logic signed [16:0] el_err;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign both_cal    = r_cal_az && r_cal_el;

    // Elevation target clamp: upper limit first, so the lower limit wins
    // when the limits cross.
    always_comb begin
        el_target = r_in.elevation_command;
        if (el_target > i_regs.elevation_upper_limit) begin
            el_target = i_regs.elevation_upper_limit;
        end
        if (el_target < i_regs.elevation_lower_limit) begin
            el_target = i_regs.elevation_lower_limit;
        end
    end

    assign az_err = 17'(r_in.azimuth_command) - 17'(r_in.azimuth_position);
    assign el_err = 17'(el_target) - 17'(r_in.elevation_position);

    always_comb begin
        n_mode    = r_mode;
        n_cal_az  = r_cal_az;
        n_cal_el  = r_cal_el;
        n_enabled = r_enabled;
        n_out.azimuth_speed             = '0;
        n_out.elevation_speed           = '0;
        n_out.calibrate_azimuth_pulse   = 1'b0;
        n_out.calibrate_elevation_pulse = 1'b0;

        unique case (r_in.action)
            ACT_IDLE: begin
                n_mode    = MODE_IDLE;
                n_enabled = both_cal;
            end
            ACT_TRACK: begin
                n_mode    = MODE_TRACK;
                n_enabled = 1'b1;
            end
            ACT_REMOTE: begin
                n_mode    = MODE_REMOTE;
                n_enabled = 1'b1;
            end
            ACT_CAL: begin
                n_mode    = MODE_CAL;
                n_enabled = 1'b1;
            end
            default: begin
                // A tick, and the unused action codes, act on the current mode.
                unique case (r_mode)
                    MODE_IDLE: begin
                        n_mode = r_mode;
                    end
                    MODE_CAL: begin
                        n_out.calibrate_azimuth_pulse   = !r_cal_az;
                        n_out.calibrate_elevation_pulse = !r_cal_el;
                        n_cal_az = 1'b1;
                        n_cal_el = 1'b1;
                    end
                    MODE_TRACK: begin
                        n_out.azimuth_speed   = prop_gain(i_regs.gain_azimuth, az_err);
                        n_out.elevation_speed = prop_gain(i_regs.gain_elevation, el_err);
                    end
                    MODE_REMOTE: begin
                        n_out.azimuth_speed   = r_in.azimuth_command;
                        n_out.elevation_speed = r_in.elevation_command;
                        // Once both axes are calibrated, stop elevation from driving further past a limit.
                        if (both_cal) begin
                            if ((r_in.elevation_position > i_regs.elevation_upper_limit
                                    && r_in.elevation_command > 16'sd0)
                                || (r_in.elevation_position < i_regs.elevation_lower_limit
                                    && r_in.elevation_command < 16'sd0)) begin
                                n_out.elevation_speed = '0;
                            end
                        end
                    end
                    default: n_mode = r_mode;
                endcase
            end
        endcase

        n_out.drives_enabled = n_enabled;
        n_out.current_mode   = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_cal_az    <= 1'b0;
            r_cal_el    <= 1'b0;
            r_enabled   <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_cal_az    <= n_cal_az;
                r_cal_el    <= n_cal_el;
                r_enabled   <= n_enabled;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: src/tpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-axis tracker port checker
// Checks result consistency and output handshake behavior at the top ports.
// ----------------------------------------------------------------------------
module tpc_checker
    import tpc_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item i_out_data
);

    // The result register is emptied by reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Calibrate strobes come only from a calibrating tick, which never drives.
    a_cal_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.calibrate_azimuth_pulse
            || i_out_data.calibrate_elevation_pulse)
        |-> i_out_data.current_mode == MODE_CAL && i_out_data.azimuth_speed == '0
            && i_out_data.elevation_speed == '0)
        else $error("calibrate strobe outside a calibrating tick");

    // Only idle can leave the drives disabled.
    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.drives_enabled |-> i_out_data.current_mode == MODE_IDLE)
        else $error("drives disabled outside idle");

    a_idle_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.current_mode == MODE_IDLE
        |-> i_out_data.azimuth_speed == '0 && i_out_data.elevation_speed == '0)
        else $error("nonzero speed in idle");

endmodule

bind two_axis_tracker_mode_p_control_top tpc_checker u_tpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
